>>> rtl/sbx_pkg.sv
`timescale 1ns / 1ps
package sbx_pkg;

   // Sizes
   localparam int STACK_DEPTH = 16;
   localparam int LOCAL_COUNT = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int BANK_DEPTH  = (STACK_DEPTH + 1) / 2;
   localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int LIDX_W      = $clog2(LOCAL_COUNT);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Opcodes
   localparam logic [7:0] OP_NOP         = 8'h00;
   localparam logic [7:0] OP_ICONST_M1   = 8'h02;
   localparam logic [7:0] OP_ICONST_5    = 8'h08;
   localparam logic [7:0] OP_BIPUSH      = 8'h10;
   localparam logic [7:0] OP_ILOAD       = 8'h15;
   localparam logic [7:0] OP_ILOAD_0     = 8'h1A;
   localparam logic [7:0] OP_ILOAD_3     = 8'h1D;
   localparam logic [7:0] OP_ISTORE      = 8'h36;
   localparam logic [7:0] OP_ISTORE_0    = 8'h3B;
   localparam logic [7:0] OP_ISTORE_3    = 8'h3E;
   localparam logic [7:0] OP_IADD        = 8'h60;
   localparam logic [7:0] OP_ISUB        = 8'h64;
   localparam logic [7:0] OP_IMUL        = 8'h68;
   localparam logic [7:0] OP_IINC        = 8'h84;
   localparam logic [7:0] OP_IFNE        = 8'h9A;
   localparam logic [7:0] OP_IFLE        = 8'h9E;
   localparam logic [7:0] OP_IF_ICMPGE   = 8'hA2;
   localparam logic [7:0] OP_IF_ICMPGT   = 8'hA3;
   localparam logic [7:0] OP_IF_ICMPLE   = 8'hA4;
   localparam logic [7:0] OP_GOTO        = 8'hA7;
   localparam logic [7:0] OP_IRETURN     = 8'hAC;
   localparam logic [7:0] OP_RETURN      = 8'hB1;
   localparam logic [7:0] OP_GETSTATIC   = 8'hB2;
   localparam logic [7:0] OP_INVOKEVIRT  = 8'hB6;
   localparam logic [7:0] OP_ICONST_BIAS = 8'h03;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_LOCAL = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      K_NOP, K_PUSH_IMM, K_LOAD, K_STORE, K_ADD, K_SUB, K_MUL, K_IINC,
      K_GOTO, K_CMPGE, K_CMPGT, K_CMPLE, K_IFNE, K_IFLE, K_PRINT,
      K_IRET, K_RET
   } kind_type;

   // Classified instruction handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  len;
      logic [1:0]  pops;
      logic        push;
      logic        uses_local;
      logic [7:0]  idx;
      logic [31:0] imm;
      logic [15:0] offset;
   } decoded_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        branch_taken;
      logic        print_valid;
      logic [31:0] print_value;
      logic        return_valid;
      logic [31:0] return_value;
      logic        done_res;
      status_type  status;
   } result_type;

endpackage

>>> rtl/sbx_channels.sv
`timescale 1ns / 1ps

interface sbx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] op;
   logic [7:0] byte_one;
   logic [7:0] byte_two;

   modport source (output valid, op, byte_one, byte_two, input ready);
   modport sink   (input valid, op, byte_one, byte_two, output ready);
endinterface

interface sbx_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] next_pc;
   logic               branch_taken;
   logic               print_valid;
   logic signed [31:0] print_value;
   logic               return_valid;
   logic signed [31:0] return_value;
   logic               done_res;
   logic        [1:0]  status;

   modport source (output valid, next_pc, branch_taken, print_valid, print_value,
                   return_valid, return_value, done_res, status, input ready);
   modport sink   (input valid, next_pc, branch_taken, print_valid, print_value,
                   return_valid, return_value, done_res, status, output ready);
endinterface

>>> rtl/sbx_front.sv
`timescale 1ns / 1ps
module sbx_front (
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         op,
   input  logic [7:0]         byte_one,
   input  logic [7:0]         byte_two,
   input  logic               q_full,
   output logic               q_push,
   output sbx_pkg::decoded_type q_data
);
   import sbx_pkg::*;

   logic [7:0] iconst_imm;

   // request accepted whenever the queue has room
   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;
   assign iconst_imm = op - OP_ICONST_BIAS;

   // classify the opcode
   always_comb begin
      q_data            = '0;
      q_data.kind       = K_NOP;
      q_data.len        = 2'd1;
      q_data.offset     = {byte_one, byte_two};
      q_data.idx        = byte_one;
      unique case (op) inside
         [OP_ICONST_M1:OP_ICONST_5]: begin
            q_data.kind = K_PUSH_IMM;
            q_data.push = 1'b1;
            q_data.imm  = {{24{iconst_imm[7]}}, iconst_imm};
         end
         OP_BIPUSH: begin
            q_data.kind = K_PUSH_IMM;
            q_data.len  = 2'd2;
            q_data.push = 1'b1;
            q_data.imm  = {{24{byte_one[7]}}, byte_one};
         end
         OP_ILOAD: begin
            q_data.kind       = K_LOAD;
            q_data.len        = 2'd2;
            q_data.push       = 1'b1;
            q_data.uses_local = 1'b1;
         end
         [OP_ILOAD_0:OP_ILOAD_3]: begin
            q_data.kind       = K_LOAD;
            q_data.push       = 1'b1;
            q_data.uses_local = 1'b1;
            q_data.idx        = op - OP_ILOAD_0;
         end
         OP_ISTORE: begin
            q_data.kind       = K_STORE;
            q_data.len        = 2'd2;
            q_data.pops       = 2'd1;
            q_data.uses_local = 1'b1;
         end
         [OP_ISTORE_0:OP_ISTORE_3]: begin
            q_data.kind       = K_STORE;
            q_data.pops       = 2'd1;
            q_data.uses_local = 1'b1;
            q_data.idx        = op - OP_ISTORE_0;
         end
         OP_IADD, OP_ISUB, OP_IMUL: begin
            q_data.kind = (op == OP_IADD) ? K_ADD : ((op == OP_ISUB) ? K_SUB : K_MUL);
            q_data.pops = 2'd2;
            q_data.push = 1'b1;
         end
         OP_IINC: begin
            q_data.kind       = K_IINC;
            q_data.len        = 2'd3;
            q_data.uses_local = 1'b1;
            q_data.imm        = {{24{byte_two[7]}}, byte_two};
         end
         OP_GOTO: begin
            q_data.kind = K_GOTO;
            q_data.len  = 2'd3;
         end
         OP_GETSTATIC: begin
            q_data.len = 2'd3;
         end
         OP_IF_ICMPGE, OP_IF_ICMPGT, OP_IF_ICMPLE: begin
            q_data.kind = (op == OP_IF_ICMPGE) ? K_CMPGE :
                          ((op == OP_IF_ICMPGT) ? K_CMPGT : K_CMPLE);
            q_data.len  = 2'd3;
            q_data.pops = 2'd2;
         end
         OP_IFNE, OP_IFLE, OP_INVOKEVIRT: begin
            q_data.kind = (op == OP_IFNE) ? K_IFNE :
                          ((op == OP_IFLE) ? K_IFLE : K_PRINT);
            q_data.len  = 2'd3;
            q_data.pops = 2'd1;
         end
         OP_IRETURN: begin
            q_data.kind = K_IRET;
            q_data.pops = 2'd1;
         end
         OP_RETURN: begin
            q_data.kind = K_RET;
         end
         default: begin
            q_data.kind = K_NOP;
         end
      endcase
   end

endmodule

>>> rtl/sbx_queue.sv
`timescale 1ns / 1ps
module sbx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbx_pkg::decoded_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sbx_pkg::decoded_type head_data
);
   import sbx_pkg::*;

   decoded_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/sbx_back.sv
`timescale 1ns / 1ps
module sbx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         code_len,
   input  logic                head_valid,
   input  sbx_pkg::decoded_type head_data,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output sbx_pkg::result_type out_data
);
   import sbx_pkg::*;

   // top three stack entries cached, full stack kept in two banks by parity
   logic [31:0]      tos_ff, tos_in, nos_ff, nos_in, thd_ff, thd_in;
   logic [31:0]      even_ff [BANK_DEPTH];
   logic [31:0]      odd_ff  [BANK_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      local_ff [LOCAL_COUNT];
   logic [15:0]      pc_ff;
   logic             halted_ff;
   logic             out_valid_ff;
   result_type       out_ff, res;

   decoded_type      d;
   logic             entry_halt, exec_ok, taken, done, pushing;
   status_type       status;
   logic [CNT_W-1:0] c4, c5, wpos;
   logic [BANK_AW-1:0] even_addr, odd_addr, wr_addr;
   logic [31:0]      even_rd, odd_rd, fill1, fill2;
   logic [31:0]      a, b, r, lval, base_t, base_n, base_h;
   logic [LIDX_W-1:0] lidx;
   logic [15:0]      npc;
   logic             ldst_wr;

   assign d         = head_data;
   assign pop       = head_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // refill reads, one address per bank
   assign c4        = cnt_ff - CNT_W'(4);
   assign c5        = cnt_ff - CNT_W'(5);
   assign even_addr = BANK_AW'(c4[0] ? (c5 >> 1) : (c4 >> 1));
   assign odd_addr  = BANK_AW'(c4[0] ? (c4 >> 1) : (c5 >> 1));
   assign even_rd   = even_ff[even_addr];
   assign odd_rd    = odd_ff[odd_addr];
   assign fill1     = c4[0] ? odd_rd : even_rd;
   assign fill2     = c5[0] ? odd_rd : even_rd;

   assign lidx = d.idx[LIDX_W-1:0];
   assign lval = local_ff[lidx];

   // entry checks, local index first, then underflow, then overflow
   always_comb begin
      entry_halt = halted_ff || (pc_ff >= code_len);
      status     = ST_OK;
      if (entry_halt) begin
         status = ST_OK;
      end else if (d.uses_local && ({1'b0, d.idx} >= 9'(LOCAL_COUNT))) begin
         status = ST_LOCAL;
      end else if (cnt_ff < CNT_W'(d.pops)) begin
         status = ST_UNDER;
      end else if (({1'b0, cnt_ff} - (CNT_W + 1)'(d.pops) + (CNT_W + 1)'(d.push))
                   > (CNT_W + 1)'(STACK_DEPTH)) begin
         status = ST_OVER;
      end
      exec_ok = !entry_halt && (status == ST_OK);
   end

   // operands and result value
   always_comb begin
      a = tos_ff;
      b = '0;
      if (d.pops == 2'd2) begin
         a = nos_ff;
         b = tos_ff;
      end
      case (d.kind)
         K_LOAD:  r = lval;
         K_ADD:   r = a + b;
         K_SUB:   r = a - b;
         K_MUL:   r = a * b;
         default: r = d.imm;
      endcase
      case (d.kind)
         K_GOTO:  taken = 1'b1;
         K_CMPGE: taken = $signed(a) >= $signed(b);
         K_CMPGT: taken = $signed(a) >  $signed(b);
         K_CMPLE: taken = $signed(a) <= $signed(b);
         K_IFNE:  taken = (a != '0);
         K_IFLE:  taken = $signed(a) <= 0;
         default: taken = 1'b0;
      endcase
      taken = taken && exec_ok;
   end

   // next stack view
   always_comb begin
      pushing = exec_ok && d.push;
      base_t  = tos_ff;
      base_n  = nos_ff;
      base_h  = thd_ff;
      if (exec_ok && d.pops == 2'd1) begin
         base_t = nos_ff;
         base_n = thd_ff;
         base_h = fill1;
      end else if (exec_ok && d.pops == 2'd2) begin
         base_t = thd_ff;
         base_n = fill1;
         base_h = fill2;
      end
      tos_in = base_t;
      nos_in = base_n;
      thd_in = base_h;
      if (pushing) begin
         tos_in = r;
         nos_in = base_t;
         thd_in = base_n;
      end
      cnt_in = cnt_ff;
      if (exec_ok) begin
         cnt_in = cnt_ff - CNT_W'(d.pops) + CNT_W'(d.push);
      end
      wpos    = cnt_ff - CNT_W'(d.pops);
      wr_addr = BANK_AW'(wpos >> 1);
   end

   // program counter and result
   always_comb begin
      if (entry_halt) begin
         npc = pc_ff;
      end else if (taken) begin
         npc = pc_ff + d.offset;
      end else begin
         npc = pc_ff + 16'(d.len);
      end
      done = entry_halt || (d.kind == K_IRET) || (d.kind == K_RET) ||
             (npc >= code_len);
      ldst_wr = exec_ok && ((d.kind == K_STORE) || (d.kind == K_IINC));
      res              = '0;
      res.next_pc      = npc;
      res.branch_taken = taken;
      res.done_res     = done;
      res.status       = status;
      if (exec_ok && d.kind == K_PRINT) begin
         res.print_valid = 1'b1;
         res.print_value = a;
      end
      if (exec_ok && d.kind == K_IRET) begin
         res.return_valid = 1'b1;
         res.return_value = a;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cnt_ff    <= cnt_in;
            pc_ff     <= npc;
            halted_ff <= done;
         end
         if (pop) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // locals clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOCAL_COUNT; i++) begin
            local_ff[i] <= '0;
         end
      end else if (pop && ldst_wr) begin
         local_ff[lidx] <= (d.kind == K_IINC) ? lval + d.imm : a;
      end
   end

   // stack payload
   always_ff @(posedge clock) begin
      if (pop) begin
         tos_ff <= tos_in;
         nos_ff <= nos_in;
         thd_ff <= thd_in;
         out_ff <= res;
         if (pushing && !wpos[0]) begin
            even_ff[wr_addr] <= r;
         end
         if (pushing && wpos[0]) begin
            odd_ff[wr_addr] <= r;
         end
      end
   end

endmodule

>>> rtl/int_stack_bytecode_executor_unit.sv
`timescale 1ns / 1ps
// Integer stack-machine bytecode executor.
// req_ch carries one instruction per request: the opcode and the two code
// bytes that follow it. rsp_ch returns one result per request, in order:
// next pc, branch taken, print and return values, halt flag and status.
// Both channels use valid/ready; a transfer happens when both are high.
// csr_wr_en/csr_wr_data write the code length; write it only while idle.
// A request that is accepted is written into the queue, then executed into the output register, where its result shows.
// Throughput: one instruction per cycle while rsp_ch does not stall, set by the execute
// stage that reads and updates the stack, locals and pc.
// A two-entry queue sits between decode and execute; the result is held in
// an output register, so a new request is taken while a result waits.
// When rsp_ch stalls, the result holds, execute stops and the queue fills;
// req_ch.ready falls once the queue is full.
// Reset (synchronous, active high) empties the stack and queue, clears the
// locals, pc and halt flag, and sets the code length to 65535.
module int_stack_bytecode_executor_unit (
   input  logic         clock,
   input  logic         reset,
   sbx_req_if.sink      req_ch,
   sbx_rsp_if.source    rsp_ch,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import sbx_pkg::*;

   logic        [15:0] code_len_ff;
   logic               q_full, q_push, q_pop, q_valid;
   decoded_type        q_in, q_head;
   result_type         res;

   // code length register
   always_ff @(posedge clock) begin
      if (reset) begin
         code_len_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         code_len_ff <= csr_wr_data;
      end
   end

   sbx_front u_front (
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .op       (req_ch.op),
      .byte_one (req_ch.byte_one),
      .byte_two (req_ch.byte_two),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   sbx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   sbx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .code_len    (code_len_ff),
      .head_valid  (q_valid),
      .head_data   (q_head),
      .pop         (q_pop),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_data    (res)
   );

   assign rsp_ch.next_pc      = res.next_pc;
   assign rsp_ch.branch_taken = res.branch_taken;
   assign rsp_ch.print_valid  = res.print_valid;
   assign rsp_ch.print_value  = res.print_value;
   assign rsp_ch.return_valid = res.return_valid;
   assign rsp_ch.return_value = res.return_value;
   assign rsp_ch.done_res     = res.done_res;
   assign rsp_ch.status       = res.status;

endmodule

>>> rtl/sbx_checker.sv
`timescale 1ns / 1ps
module sbx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       branch_taken,
   input logic       print_valid,
   input logic       return_valid,
   input logic       done_res,
   input logic [1:0] status
);
   import sbx_pkg::*;

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // branches only on clean instructions
   a_branch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && branch_taken |-> status == ST_OK)
      else $error("branch taken with error status");

   // a returned value always halts and never comes with a print
   a_return_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && return_valid |-> done_res && !print_valid)
      else $error("return without halt");

   // print output is never flagged with an error or with a branch
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && print_valid |-> status == ST_OK && !branch_taken)
      else $error("print with error or branch");

endmodule

bind int_stack_bytecode_executor_unit sbx_checker u_sbx_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .branch_taken (rsp_ch.branch_taken),
   .print_valid  (rsp_ch.print_valid),
   .return_valid (rsp_ch.return_valid),
   .done_res     (rsp_ch.done_res),
   .status       (rsp_ch.status)
);

>>> dv/int_stack_bytecode_executor_checker.sv
`timescale 1ns / 1ps
module int_stack_bytecode_executor_checker (
   input  logic        clock,
   input  logic        reset,
   sbx_req_if          req_ch,
   sbx_rsp_if          rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatches,
   output int          in_flight,
   output logic [15:0] model_pc
);
   import sbx_pkg::*;

   // Shadow machine state
   logic [31:0] stack_mem [STACK_DEPTH];
   int          depth;
   logic [31:0] locals_mem [LOCAL_COUNT];
   logic [15:0] pc;
   bit          stopped;
   logic [15:0] code_len;

   result_type  expected_q [$];

   assign model_pc = pc;

   // Execute one instruction on the shadow state, return its result
   function automatic result_type execute_insn(logic [7:0] op, logic [7:0] b1,
                                               logic [7:0] b2);
      result_type  r;
      logic [7:0]  o;
      logic [15:0] len;
      logic [15:0] npc;
      logic [15:0] tgt;
      int          pops;
      int          pushes;
      bit          use_loc;
      logic [7:0]  idx;
      logic [31:0] a;
      logic [31:0] b;
      bit          tk;
      status_type  st;
      r = '0;
      r.status = ST_OK;
      if (stopped || pc >= code_len) begin
         stopped = 1;
         r.next_pc = pc;
         r.done_res = 1;
         return r;
      end
      o = op; len = 1; pops = 0; pushes = 0; use_loc = 0; idx = '0; tk = 0;
      a = '0; b = '0; st = ST_OK;
      // decode
      if (o >= OP_ICONST_M1 && o <= OP_ICONST_5) pushes = 1;
      else if (o == OP_BIPUSH) begin len = 2; pushes = 1; end
      else if (o == OP_ILOAD) begin len = 2; pushes = 1; idx = b1; use_loc = 1; end
      else if (o >= OP_ILOAD_0 && o <= OP_ILOAD_3) begin
         pushes = 1; idx = o - OP_ILOAD_0; use_loc = 1;
      end
      else if (o == OP_ISTORE) begin len = 2; pops = 1; idx = b1; use_loc = 1; end
      else if (o >= OP_ISTORE_0 && o <= OP_ISTORE_3) begin
         pops = 1; idx = o - OP_ISTORE_0; use_loc = 1;
      end
      else if (o == OP_IADD || o == OP_ISUB || o == OP_IMUL) begin
         pops = 2; pushes = 1;
      end
      else if (o == OP_IINC) begin len = 3; idx = b1; use_loc = 1; end
      else if (o == OP_GOTO || o == OP_GETSTATIC) len = 3;
      else if (o == OP_IF_ICMPGE || o == OP_IF_ICMPGT || o == OP_IF_ICMPLE) begin
         len = 3; pops = 2;
      end
      else if (o == OP_IFNE || o == OP_IFLE || o == OP_INVOKEVIRT) begin
         len = 3; pops = 1;
      end
      else if (o == OP_IRETURN) pops = 1;
      else if (o == OP_RETURN) ;
      else o = OP_NOP;

      // local index first, then underflow, then overflow
      if (use_loc && idx >= LOCAL_COUNT) st = ST_LOCAL;
      else if (depth < pops) st = ST_UNDER;
      else if (depth - pops + pushes > STACK_DEPTH) st = ST_OVER;

      if (o == OP_IRETURN || o == OP_RETURN) begin
         stopped = 1;
         r.done_res = 1;
      end

      if (st == ST_OK) begin
         if (pops == 2) begin
            b = stack_mem[depth-1];
            a = stack_mem[depth-2];
            depth -= 2;
         end else if (pops == 1) begin
            a = stack_mem[depth-1];
            depth -= 1;
         end
         tgt = pc + {b1, b2};
         case (o) inside
            OP_BIPUSH: begin
               stack_mem[depth] = {{24{b1[7]}}, b1}; depth++;
            end
            OP_ILOAD, [OP_ILOAD_0:OP_ILOAD_3]: begin
               stack_mem[depth] = locals_mem[idx]; depth++;
            end
            OP_ISTORE, [OP_ISTORE_0:OP_ISTORE_3]: locals_mem[idx] = a;
            OP_IADD: begin stack_mem[depth] = a + b; depth++; end
            OP_ISUB: begin stack_mem[depth] = a - b; depth++; end
            OP_IMUL: begin stack_mem[depth] = a * b; depth++; end
            OP_IINC: locals_mem[idx] = locals_mem[idx] + {{24{b2[7]}}, b2};
            OP_GOTO: tk = 1;
            OP_IF_ICMPGE: tk = $signed(a) >= $signed(b);
            OP_IF_ICMPGT: tk = $signed(a) > $signed(b);
            OP_IF_ICMPLE: tk = $signed(a) <= $signed(b);
            OP_IFNE: tk = (a != 0);
            OP_IFLE: tk = $signed(a) <= 0;
            OP_INVOKEVIRT: begin r.print_valid = 1; r.print_value = a; end
            OP_IRETURN: begin r.return_valid = 1; r.return_value = a; end
            default: begin
               if (o >= OP_ICONST_M1 && o <= OP_ICONST_5) begin
                  stack_mem[depth] = {24'b0, o} - {24'b0, OP_ICONST_BIAS};
                  depth++;
               end
            end
         endcase
      end
      npc = tk ? tgt : pc + len;
      pc = npc;
      if (npc >= code_len) begin
         stopped = 1;
         r.done_res = 1;
      end
      r.next_pc = npc;
      r.branch_taken = tk;
      r.status = st;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // Observe config writes, results and requests at each rising edge
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         depth = 0; pc = '0; stopped = 0; code_len = 16'hFFFF;
         foreach (locals_mem[i]) locals_mem[i] = '0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) code_len = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result: expected none, actual pc %h",
                        $time, rsp_ch.next_pc);
               mismatches++;
            end else begin
               e = expected_q.pop_front();
               check_field("next_pc", e.next_pc, rsp_ch.next_pc);
               check_field("branch_taken", e.branch_taken, rsp_ch.branch_taken);
               check_field("print_valid", e.print_valid, rsp_ch.print_valid);
               check_field("print_value", e.print_value, rsp_ch.print_value);
               check_field("return_valid", e.return_valid, rsp_ch.return_valid);
               check_field("return_value", e.return_value, rsp_ch.return_value);
               check_field("done_res", e.done_res, rsp_ch.done_res);
               check_field("status", e.status, rsp_ch.status);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(execute_insn(req_ch.op, req_ch.byte_one, req_ch.byte_two));
      end
      in_flight = expected_q.size();
   end

   initial begin
      mismatches = 0;
      in_flight = 0;
   end

endmodule

>>> dv/int_stack_bytecode_executor_unit_tb.sv
`timescale 1ns / 1ps
module int_stack_bytecode_executor_unit_tb;
   import sbx_pkg::*;

   localparam logic [7:0] OP_INVOKESTATIC = 8'hB8;
   localparam int         STALL_LIMIT     = 5000;
   localparam int         HOLD_CYCLES     = 300;
   localparam int         PHASES          = 7;
   localparam int         PHASE_ITEMS     = 250;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = '0;
   int          mismatches;
   int          in_flight;
   logic [15:0] model_pc;
   bit          hold_req = 0;
   bit          no_gaps = 0;
   int          quiet_cycles = 0;

   sbx_req_if req_ch ();
   sbx_rsp_if rsp_ch ();

   always #10 clock = ~clock;

   int_stack_bytecode_executor_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   int_stack_bytecode_executor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .in_flight   (in_flight),
      .model_pc    (model_pc)
   );

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
      int n;
      @(negedge clock);
      req_ch.op <= op;
      req_ch.byte_one <= b1;
      req_ch.byte_two <= b2;
      req_ch.valid <= 1;
      do @(posedge clock); while (!req_ch.ready);
      n = gap_len();
      if (n > 0) begin
         @(negedge clock);
         req_ch.valid <= 0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_code_len(logic [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // Random instruction; push_bias raises the share of stack pushes.
   // Halting opcodes are left out and branch offsets stay small and forward.
   task automatic random_insn(int push_bias);
      logic [7:0] op;
      logic [7:0] b1;
      logic [7:0] b2;
      int         r;
      r = $urandom_range(0, 99);
      b1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      b2 = 8'($urandom);
      if (r < push_bias) begin
         case ($urandom_range(0, 3))
            0: op = 8'($urandom_range(OP_ICONST_M1, OP_ICONST_5));
            1: begin op = OP_BIPUSH; b1 = 8'($urandom); end
            2: op = OP_ILOAD;
            default: op = 8'($urandom_range(OP_ILOAD_0, OP_ILOAD_3));
         endcase
      end else if (r < push_bias + 35) begin
         case ($urandom_range(0, 5))
            0: op = OP_ISTORE;
            1: op = 8'($urandom_range(OP_ISTORE_0, OP_ISTORE_3));
            2: op = OP_IADD;
            3: op = OP_ISUB;
            4: op = OP_IMUL;
            default: op = OP_INVOKEVIRT;
         endcase
      end else if (r < push_bias + 50) begin
         case ($urandom_range(0, 5))
            0: op = OP_IF_ICMPGE;
            1: op = OP_IF_ICMPGT;
            2: op = OP_IF_ICMPLE;
            3: op = OP_IFNE;
            4: op = OP_IFLE;
            default: op = OP_GOTO;
         endcase
         b1 = '0;
         b2 = 8'($urandom_range(0, 15));
      end else if (r < push_bias + 60) begin
         op = OP_IINC;
      end else begin
         // any other byte: getstatic, nop, unknown opcodes
         do op = 8'($urandom);
         while (op == OP_IRETURN || op == OP_RETURN || op == OP_GOTO ||
                op == OP_IF_ICMPGE || op == OP_IF_ICMPGT || op == OP_IF_ICMPLE ||
                op == OP_IFNE || op == OP_IFLE);
      end
      send(op, b1, b2);
   endtask

   // Result side: random backpressure, one long hold on request
   initial begin
      int n;
      rsp_ch.ready = 0;
      forever begin
         if (hold_req) begin
            @(negedge clock);
            rsp_ch.ready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end else begin
            n = gap_len();
            if (n > 0) begin
               @(negedge clock);
               rsp_ch.ready <= 0;
               repeat (n - 1) @(negedge clock);
            end
            @(negedge clock);
            rsp_ch.ready <= 1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [16:0] lim;
      req_ch.valid = 0;
      req_ch.op = '0;
      req_ch.byte_one = '0;
      req_ch.byte_two = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_code_len(16'hFFFF);

      // directed: field extremes, every non-halting operation, error cases
      send(OP_ISUB, 8'h00, 8'h00);          // underflow on empty stack
      send(OP_ICONST_M1, 8'h00, 8'h00);
      send(OP_ICONST_5, 8'h00, 8'h00);
      send(OP_IADD, 8'h00, 8'h00);
      send(OP_BIPUSH, 8'h80, 8'h00);
      send(OP_BIPUSH, 8'h7F, 8'hFF);
      send(OP_IMUL, 8'h00, 8'h00);
      send(OP_ISUB, 8'h00, 8'h00);
      send(OP_ISTORE_0, 8'h00, 8'h00);
      send(OP_ILOAD_0, 8'h00, 8'h00);
      send(OP_ISTORE, 8'd15, 8'h00);
      send(OP_ILOAD, 8'd15, 8'h00);
      send(OP_ILOAD, 8'd16, 8'h00);         // local index out of range
      send(OP_ISTORE, 8'hFF, 8'h00);        // bad index wins over the pop
      send(OP_IINC, 8'd15, 8'h80);
      send(OP_IINC, 8'h00, 8'h7F);
      send(OP_ILOAD_3, 8'h00, 8'h00);
      send(OP_IFLE, 8'h00, 8'h06);
      send(OP_GOTO, 8'h00, 8'h05);
      send(OP_GOTO, 8'hFF, 8'hFD);          // backward branch
      send(OP_GETSTATIC, 8'hFF, 8'hFF);
      send(OP_INVOKEVIRT, 8'h00, 8'h00);    // pops the iload value
      send(OP_INVOKESTATIC, 8'hAA, 8'h55);  // unknown, one-byte nop
      send(OP_NOP, 8'h00, 8'h00);
      for (int i = 0; i < 18; i++) send(OP_ICONST_M1 + 8'(i % 7), 8'h00, 8'h00);
      send(OP_IF_ICMPGE, 8'h00, 8'h03);
      send(OP_IF_ICMPGT, 8'h00, 8'h03);
      send(OP_IF_ICMPLE, 8'h00, 8'h03);
      send(OP_IFNE, 8'h00, 8'h03);

      // random phases with changing code length, bias and idling
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         lim = {1'b0, model_pc} + 17'd30000 + 17'($urandom_range(0, 5000));
         write_code_len((p % 2 == 0 || lim > 17'hFFFF) ? 16'hFFFF : lim[15:0]);
         no_gaps = (p == 2);
         if (p == 3) hold_req = 1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_insn((p == 4) ? 60 : 30);
      end

      // halt after two instructions, then requests while halted with code length 0
      wait_idle();
      lim = {1'b0, model_pc} + 17'd2;
      write_code_len(lim > 17'hFFFF ? 16'hFFFF : lim[15:0]);
      send(OP_ICONST_M1 + 8'd3, 8'h00, 8'h00);
      send(OP_ICONST_M1 + 8'd4, 8'h00, 8'h00);
      wait_idle();
      write_code_len(16'h0000);
      send(OP_IRETURN, 8'h00, 8'h00);
      send(OP_RETURN, 8'h00, 8'h00);
      send(OP_NOP, 8'h00, 8'h00);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
